/* src/tdhb_pkg.sv */
// Shared constants, register codes, state and divider result types for the
// two-dimensional histogram binner. No dependencies.
`default_nettype none

package tdhb_pkg;

   localparam int MAX_M_BINS  = 64;
   localparam int MAX_Z_BINS  = 64;
   localparam int COUNT_WIDTH = 32;

   localparam int VALUE_W     = 32;
   localparam int WIDTH_W     = 31;
   localparam int BINS_W      = 7;
   localparam int FIELD_IDX_W = 6;
   localparam int RSP_COUNT_W = 32;

   localparam int M_IDX_W     = $clog2(MAX_M_BINS);
   localparam int Z_IDX_W     = $clog2(MAX_Z_BINS);
   localparam int ADDR_W      = M_IDX_W + Z_IDX_W;
   localparam int DIV_Q_W     = (M_IDX_W > Z_IDX_W) ? M_IDX_W : Z_IDX_W;
   localparam int DIV_STEP_W  = $clog2(DIV_Q_W + 1);
   localparam int CMP_W       = ((DIV_Q_W > BINS_W) ? DIV_Q_W : BINS_W) + 1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_M_LOWER = 3'd0,
      CSR_M_WIDTH = 3'd1,
      CSR_Z_LOWER = 3'd2,
      CSR_Z_WIDTH = 3'd3,
      CSR_M_BINS  = 3'd4,
      CSR_Z_BINS  = 3'd5
   } tdhb_csr_type;

   localparam logic [VALUE_W-1:0] M_LOWER_RST = 32'd1179648;
   localparam logic [WIDTH_W-1:0] M_WIDTH_RST = 31'd8025;
   localparam logic [VALUE_W-1:0] Z_LOWER_RST = 32'd0;
   localparam logic [WIDTH_W-1:0] Z_WIDTH_RST = 31'd5350;
   localparam logic [BINS_W-1:0]  M_BINS_RST  = 7'd50;
   localparam logic [BINS_W-1:0]  Z_BINS_RST  = 7'd50;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_UPDATE
   } tdhb_state_type;

   typedef struct packed {
      logic               busy;
      logic               fit;
      logic [DIV_Q_W-1:0] quot;
   } tdhb_div_res_type;

endpackage

`default_nettype wire

/* src/tdhb_req_if.sv */
// Request channel of the histogram binner: valid/ready plus request fields.
// Depends on tdhb_pkg.
`default_nettype none

interface tdhb_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic signed [tdhb_pkg::VALUE_W-1:0] magnitude;
   logic signed [tdhb_pkg::VALUE_W-1:0] redshift;
   logic [tdhb_pkg::FIELD_IDX_W-1:0]    read_m_bin;
   logic [tdhb_pkg::FIELD_IDX_W-1:0]    read_z_bin;

   modport source (output valid, mode, magnitude, redshift, read_m_bin, read_z_bin,
                   input ready);
   modport sink (input valid, mode, magnitude, redshift, read_m_bin, read_z_bin,
                 output ready);
endinterface

`default_nettype wire

/* src/tdhb_rsp_if.sv */
// Response channel of the histogram binner: valid/ready plus result fields.
// Depends on tdhb_pkg.
`default_nettype none

interface tdhb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             in_range;
   logic [tdhb_pkg::FIELD_IDX_W-1:0] placed_m_bin;
   logic [tdhb_pkg::FIELD_IDX_W-1:0] placed_z_bin;
   logic [tdhb_pkg::RSP_COUNT_W-1:0] bin_count;

   modport source (output valid, in_range, placed_m_bin, placed_z_bin, bin_count,
                   input ready);
   modport sink (input valid, in_range, placed_m_bin, placed_z_bin, bin_count,
                 output ready);
endinterface

`default_nettype wire

/* src/two_dim_histogram_binner.sv */
// Top level of the two-dimensional histogram binner.
// Depends on tdhb_pkg, tdhb_req_if, tdhb_rsp_if, tdhb_div and tdhb_store.
//
// After reset the block sweeps the counter store to zero, one entry per cycle,
// and takes no request until done. Each request then occupies the block through
// these steps in order: accept, the bit-serial dividers that place magnitude
// and redshift in parallel, the store read, and the update of the counter and
// the load of the response register, which waits until that register is free.
// A finished response waits in that register while the next request is taken.
// Read requests run the same sequence.
`default_nettype none

module two_dim_histogram_binner (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tdhb_req_if.sink                                 req_chan,
   tdhb_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [tdhb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [tdhb_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int CW = tdhb_pkg::COUNT_WIDTH;
   localparam int MW = tdhb_pkg::M_IDX_W;
   localparam int ZW = tdhb_pkg::Z_IDX_W;
   localparam int AW = tdhb_pkg::ADDR_W;
   localparam int PW = tdhb_pkg::CMP_W;
   localparam int FW = tdhb_pkg::FIELD_IDX_W;

   // configuration
   logic [tdhb_pkg::VALUE_W-1:0] m_lower_ff;
   logic [tdhb_pkg::WIDTH_W-1:0] m_width_ff;
   logic [tdhb_pkg::VALUE_W-1:0] z_lower_ff;
   logic [tdhb_pkg::WIDTH_W-1:0] z_width_ff;
   logic [tdhb_pkg::BINS_W-1:0]  m_bins_ff;
   logic [tdhb_pkg::BINS_W-1:0]  z_bins_ff;

   tdhb_pkg::tdhb_state_type     state_ff, state_in;
   logic [AW-1:0]                clr_ff, clr_in;

   logic                         mode_ff;
   logic [FW-1:0]                rd_m_ff;
   logic [FW-1:0]                rd_z_ff;
   logic                         ok_ff, ok_in;
   logic [MW-1:0]                m_idx_ff, m_idx_in;
   logic [ZW-1:0]                z_idx_ff, z_idx_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_range_ff;
   logic [FW-1:0]                rsp_m_ff;
   logic [FW-1:0]                rsp_z_ff;
   logic [tdhb_pkg::RSP_COUNT_W-1:0] rsp_count_ff;

   tdhb_pkg::tdhb_div_res_type   m_res, z_res;

   logic                         accept;
   logic                         div_done;
   logic                         rsp_free;
   logic                         rsp_load;
   logic [PW-1:0]                m_used, z_used, sel_m, sel_z;
   logic [CW-1:0]                rd_data, cnt_new;
   logic                         mem_wr_en, mem_rd_en;
   logic [AW-1:0]                mem_wr_addr;
   logic [CW-1:0]                mem_wr_data;

   tdhb_div u_div_m (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .value (req_chan.magnitude),
      .lower (m_lower_ff),
      .width (m_width_ff),
      .res   (m_res)
   );

   tdhb_div u_div_z (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .value (req_chan.redshift),
      .lower (z_lower_ff),
      .width (z_width_ff),
      .res   (z_res)
   );

   tdhb_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr ({m_idx_in, z_idx_in}),
      .rd_data (rd_data)
   );

   // bins in use, capped at the store size
   always_comb begin
      m_used = (PW'(m_bins_ff) > PW'(tdhb_pkg::MAX_M_BINS)) ?
               PW'(tdhb_pkg::MAX_M_BINS) : PW'(m_bins_ff);
      z_used = (PW'(z_bins_ff) > PW'(tdhb_pkg::MAX_Z_BINS)) ?
               PW'(tdhb_pkg::MAX_Z_BINS) : PW'(z_bins_ff);
      sel_m  = (mode_ff == tdhb_pkg::MODE_READ) ? PW'(rd_m_ff) : PW'(m_res.quot);
      sel_z  = (mode_ff == tdhb_pkg::MODE_READ) ? PW'(rd_z_ff) : PW'(z_res.quot);
      ok_in  = ((mode_ff == tdhb_pkg::MODE_READ) || (m_res.fit && z_res.fit)) &&
               (sel_m < m_used) && (sel_z < z_used);
      m_idx_in = MW'(sel_m);
      z_idx_in = ZW'(sel_z);
      cnt_new  = ((mode_ff == tdhb_pkg::MODE_ADD) && (rd_data != '1)) ?
                 rd_data + CW'(1) : rd_data;
   end

   assign accept   = req_chan.valid && req_chan.ready;
   assign div_done = !m_res.busy && !z_res.busy;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdhb_pkg::ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = tdhb_pkg::ST_IDLE;
            end
         end
         tdhb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tdhb_pkg::ST_DIV;
            end
         end
         tdhb_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = tdhb_pkg::ST_UPDATE;
            end
         end
         tdhb_pkg::ST_UPDATE: begin
            if (rsp_free) begin
               state_in = tdhb_pkg::ST_IDLE;
            end
         end
         default: state_in = tdhb_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = clr_ff;
      mem_wr_data    = '0;
      mem_rd_en      = 1'b0;
      rsp_load       = 1'b0;
      clr_in         = clr_ff;
      unique case (state_ff)
         tdhb_pkg::ST_CLEAR: begin
            mem_wr_en = 1'b1;
            clr_in    = clr_ff + 1'b1;
         end
         tdhb_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         tdhb_pkg::ST_DIV: begin
            mem_rd_en = div_done;
         end
         tdhb_pkg::ST_UPDATE: begin
            rsp_load    = rsp_free;
            mem_wr_en   = rsp_free && (mode_ff == tdhb_pkg::MODE_ADD) && ok_ff;
            mem_wr_addr = {m_idx_ff, z_idx_ff};
            mem_wr_data = cnt_new;
         end
         default: ;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdhb_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         m_lower_ff   <= tdhb_pkg::M_LOWER_RST;
         m_width_ff   <= tdhb_pkg::M_WIDTH_RST;
         z_lower_ff   <= tdhb_pkg::Z_LOWER_RST;
         z_width_ff   <= tdhb_pkg::Z_WIDTH_RST;
         m_bins_ff    <= tdhb_pkg::M_BINS_RST;
         z_bins_ff    <= tdhb_pkg::Z_BINS_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (tdhb_pkg::tdhb_csr_type'(csr_index))
               tdhb_pkg::CSR_M_LOWER: m_lower_ff <= csr_wr_data;
               tdhb_pkg::CSR_M_WIDTH: m_width_ff <= csr_wr_data[tdhb_pkg::WIDTH_W-1:0];
               tdhb_pkg::CSR_Z_LOWER: z_lower_ff <= csr_wr_data;
               tdhb_pkg::CSR_Z_WIDTH: z_width_ff <= csr_wr_data[tdhb_pkg::WIDTH_W-1:0];
               tdhb_pkg::CSR_M_BINS:  m_bins_ff  <= csr_wr_data[tdhb_pkg::BINS_W-1:0];
               tdhb_pkg::CSR_Z_BINS:  z_bins_ff  <= csr_wr_data[tdhb_pkg::BINS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_chan.mode;
         rd_m_ff <= req_chan.read_m_bin;
         rd_z_ff <= req_chan.read_z_bin;
      end
      if (mem_rd_en) begin
         ok_ff    <= ok_in;
         m_idx_ff <= m_idx_in;
         z_idx_ff <= z_idx_in;
      end
      if (rsp_load) begin
         rsp_range_ff <= ok_ff;
         rsp_m_ff     <= ok_ff ? FW'(m_idx_ff) : '0;
         rsp_z_ff     <= ok_ff ? FW'(z_idx_ff) : '0;
         rsp_count_ff <= ok_ff ? tdhb_pkg::RSP_COUNT_W'(cnt_new) : '0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.in_range     = rsp_range_ff;
   assign rsp_chan.placed_m_bin = rsp_m_ff;
   assign rsp_chan.placed_z_bin = rsp_z_ff;
   assign rsp_chan.bin_count    = rsp_count_ff;

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.in_range) |->
         (rsp_chan.placed_m_bin == '0) && (rsp_chan.placed_z_bin == '0) &&
         (rsp_chan.bin_count == '0))
      else $error("out-of-range response carries nonzero fields");

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == tdhb_pkg::ST_DIV) && m_res.busy && z_res.busy)
      else $error("accepted request did not start both dividers");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == tdhb_pkg::ST_CLEAR) ||
         ((state_ff == tdhb_pkg::ST_UPDATE) && (mode_ff == tdhb_pkg::MODE_ADD) && ok_ff))
      else $error("store written outside clear or in-range add");

   a_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && (state_ff == tdhb_pkg::ST_UPDATE)) |-> (mem_wr_data != '0))
      else $error("bin counter wrapped to zero");

endmodule

`default_nettype wire

/* src/tdhb_div.sv */
// Bit-serial restoring divider: bin index of (value - lower) / width.
// Range-checks the high quotient bits up front. Depends on tdhb_pkg.
`default_nettype none

module tdhb_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [tdhb_pkg::VALUE_W-1:0]   value,
   input  wire logic [tdhb_pkg::VALUE_W-1:0]   lower,
   input  wire logic [tdhb_pkg::WIDTH_W-1:0]   width,
   output tdhb_pkg::tdhb_div_res_type          res
);

   localparam int QW = tdhb_pkg::DIV_Q_W;
   localparam int WW = tdhb_pkg::WIDTH_W;
   localparam int VW = tdhb_pkg::VALUE_W;

   logic                              active_ff, active_in;
   logic [tdhb_pkg::DIV_STEP_W-1:0]   step_ff, step_in;
   logic                              fit_ff, fit_in;
   logic [WW-1:0]                     rem_ff, rem_in;
   logic [QW-1:0]                     lo_ff, lo_in;
   logic [QW-1:0]                     quot_ff, quot_in;

   logic [VW:0]                       diff;
   logic [VW-1:0]                     hi;
   logic [VW-1:0]                     trial;
   logic [VW-1:0]                     divisor;
   logic                              take;

   always_comb begin
      diff    = {value[VW-1], value} - {lower[VW-1], lower};
      hi      = diff[VW-1:0] >> QW;
      divisor = {1'b0, width};
      trial   = {rem_ff, lo_ff[QW-1]};
      take    = (trial >= divisor);

      active_in = active_ff;
      step_in   = step_ff;
      fit_in    = fit_ff;
      rem_in    = rem_ff;
      lo_in     = lo_ff;
      quot_in   = quot_ff;

      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         // negative offset, zero width, or quotient beyond the index range
         fit_in    = !diff[VW] && (width != '0) && (hi < divisor);
         rem_in    = hi[WW-1:0];
         lo_in     = diff[QW-1:0];
         quot_in   = '0;
      end else if (active_ff) begin
         rem_in  = take ? WW'(trial - divisor) : trial[WW-1:0];
         lo_in   = lo_ff << 1;
         quot_in = QW'({quot_ff, take});
         step_in = step_ff + 1'b1;
         if (step_ff == tdhb_pkg::DIV_STEP_W'(QW - 1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      fit_ff  <= fit_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      quot_ff <= quot_in;
   end

   assign res.busy = active_ff;
   assign res.fit  = fit_ff;
   assign res.quot = quot_ff;

endmodule

`default_nettype wire

/* src/tdhb_store.sv */
// Bin counter store: one write port, one registered read port.
// Depends on tdhb_pkg.
`default_nettype none

module tdhb_store (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [tdhb_pkg::ADDR_W-1:0]         wr_addr,
   input  wire logic [tdhb_pkg::COUNT_WIDTH-1:0]    wr_data,
   input  wire logic                                rd_en,
   input  wire logic [tdhb_pkg::ADDR_W-1:0]         rd_addr,
   output logic      [tdhb_pkg::COUNT_WIDTH-1:0]    rd_data
);

   logic [tdhb_pkg::COUNT_WIDTH-1:0] mem [2**tdhb_pkg::ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sim/two_dim_histogram_binner_test.sv */
// Self-checking testbench for two_dim_histogram_binner: random and directed
// sample/read requests, a local bin-count predictor and in-order response checks.
// Depends on tdhb_pkg, tdhb_req_if, tdhb_rsp_if and the binner RTL.
`default_nettype none

module two_dim_histogram_binner_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AT     = 760;
   localparam int HOLD_CYCLES = 400;
   localparam logic [tdhb_pkg::CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [tdhb_pkg::CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct packed {
      logic                             mode;
      logic [tdhb_pkg::VALUE_W-1:0]     magnitude;
      logic [tdhb_pkg::VALUE_W-1:0]     redshift;
      logic [tdhb_pkg::FIELD_IDX_W-1:0] read_m_bin;
      logic [tdhb_pkg::FIELD_IDX_W-1:0] read_z_bin;
   } bin_request_type;

   typedef struct packed {
      logic                             in_range;
      logic [tdhb_pkg::FIELD_IDX_W-1:0] placed_m_bin;
      logic [tdhb_pkg::FIELD_IDX_W-1:0] placed_z_bin;
      logic [tdhb_pkg::RSP_COUNT_W-1:0] bin_count;
   } bin_result_type;

   logic clock;
   logic reset;
   logic                             csr_wr_en;
   logic [tdhb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tdhb_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   tdhb_req_if req_chan ();
   tdhb_rsp_if rsp_chan ();

   two_dim_histogram_binner u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [tdhb_pkg::COUNT_WIDTH-1:0] hist_counts [tdhb_pkg::MAX_M_BINS*tdhb_pkg::MAX_Z_BINS];
   logic [tdhb_pkg::VALUE_W-1:0]     cfg_m_lower = tdhb_pkg::M_LOWER_RST;
   logic [tdhb_pkg::WIDTH_W-1:0]     cfg_m_width = tdhb_pkg::M_WIDTH_RST;
   logic [tdhb_pkg::VALUE_W-1:0]     cfg_z_lower = tdhb_pkg::Z_LOWER_RST;
   logic [tdhb_pkg::WIDTH_W-1:0]     cfg_z_width = tdhb_pkg::Z_WIDTH_RST;
   logic [tdhb_pkg::BINS_W-1:0]      cfg_m_bins  = tdhb_pkg::M_BINS_RST;
   logic [tdhb_pkg::BINS_W-1:0]      cfg_z_bins  = tdhb_pkg::Z_BINS_RST;

   bin_request_type pending_requests [$];
   bin_result_type  expected_results [$];
   bin_request_type next_request;
   bin_result_type  want;

   int send_idle_pct = 16;
   int recv_idle_pct = 63;
   int error_count = 0;
   int responses_seen = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int cycle_count = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int unsigned bins_used(logic [tdhb_pkg::BINS_W-1:0] b,
                                             int unsigned cap);
      return (b > cap) ? cap : b;
   endfunction

   function automatic bit locate_bin(logic [tdhb_pkg::VALUE_W-1:0] value,
                                     logic [tdhb_pkg::VALUE_W-1:0] lower,
                                     logic [tdhb_pkg::WIDTH_W-1:0] width,
                                     int unsigned count,
                                     output logic [tdhb_pkg::FIELD_IDX_W-1:0] idx);
      logic [tdhb_pkg::VALUE_W:0] diff;
      logic [tdhb_pkg::VALUE_W:0] quot;
      idx = '0;
      diff = {value[tdhb_pkg::VALUE_W-1], value} - {lower[tdhb_pkg::VALUE_W-1], lower};
      if (width == 0 || diff[tdhb_pkg::VALUE_W])
         return 0;
      quot = diff / {2'b00, width};
      if (quot >= count)
         return 0;
      idx = quot[tdhb_pkg::FIELD_IDX_W-1:0];
      return 1;
   endfunction

   function automatic bin_result_type predict_bin_result(bin_request_type r);
      bin_result_type res;
      int unsigned mb, zb, addr;
      logic [tdhb_pkg::FIELD_IDX_W-1:0] mi, zi;
      bit ok;
      mb = bins_used(cfg_m_bins, tdhb_pkg::MAX_M_BINS);
      zb = bins_used(cfg_z_bins, tdhb_pkg::MAX_Z_BINS);
      res = '0;
      mi = '0;
      zi = '0;
      if (r.mode == tdhb_pkg::MODE_ADD) begin
         ok = locate_bin(r.magnitude, cfg_m_lower, cfg_m_width, mb, mi);
         if (ok)
            ok = locate_bin(r.redshift, cfg_z_lower, cfg_z_width, zb, zi);
         if (ok) begin
            addr = mi * tdhb_pkg::MAX_Z_BINS + zi;
            if (hist_counts[addr] != '1)
               hist_counts[addr] = hist_counts[addr] + 1'b1;
         end
      end else begin
         mi = r.read_m_bin;
         zi = r.read_z_bin;
         ok = (mi < mb) && (zi < zb);
      end
      if (ok) begin
         res.in_range = 1'b1;
         res.placed_m_bin = mi;
         res.placed_z_bin = zi;
         res.bin_count =
            hist_counts[mi * tdhb_pkg::MAX_Z_BINS + zi][tdhb_pkg::RSP_COUNT_W-1:0];
      end
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_results.insert(expected_results.size(),
               predict_bin_result({req_chan.mode, req_chan.magnitude, req_chan.redshift,
                                   req_chan.read_m_bin, req_chan.read_z_bin}));
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_request = pending_requests.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.mode       <= next_request.mode;
               req_chan.magnitude  <= next_request.magnitude;
               req_chan.redshift   <= next_request.redshift;
               req_chan.read_m_bin <= next_request.read_m_bin;
               req_chan.read_z_bin <= next_request.read_z_bin;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            responses_seen++;
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.in_range !== want.in_range) begin
                  $error("in_range expected %0d got %0d", want.in_range, rsp_chan.in_range);
                  error_count++;
               end
               if (rsp_chan.placed_m_bin !== want.placed_m_bin) begin
                  $error("placed_m_bin expected %0d got %0d", want.placed_m_bin,
                         rsp_chan.placed_m_bin);
                  error_count++;
               end
               if (rsp_chan.placed_z_bin !== want.placed_z_bin) begin
                  $error("placed_z_bin expected %0d got %0d", want.placed_z_bin,
                         rsp_chan.placed_z_bin);
                  error_count++;
               end
               if (rsp_chan.bin_count !== want.bin_count) begin
                  $error("bin_count expected %0d got %0d", want.bin_count, rsp_chan.bin_count);
                  error_count++;
               end
            end
         end
         if (!hold_done && responses_seen == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic add_request(logic mode, logic [tdhb_pkg::VALUE_W-1:0] mag,
                              logic [tdhb_pkg::VALUE_W-1:0] red,
                              logic [tdhb_pkg::FIELD_IDX_W-1:0] rm,
                              logic [tdhb_pkg::FIELD_IDX_W-1:0] rz);
      pending_requests.insert(pending_requests.size(), {mode, mag, red, rm, rz});
   endtask

   function automatic logic [tdhb_pkg::VALUE_W-1:0] pick_coord(
         logic [tdhb_pkg::VALUE_W-1:0] lower, logic [tdhb_pkg::WIDTH_W-1:0] width,
         int unsigned count);
      logic [tdhb_pkg::VALUE_W-1:0] step, off;
      int unsigned k;
      if (width == 0)
         return $urandom;
      case ($urandom_range(9))
         6: return lower - $urandom_range(1, 3);
         7: return $urandom;
         8: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         9: return lower;
         default: begin
            k = $urandom_range(count);
            step = k * {1'b0, width};
            case ($urandom_range(3))
               0: off = 0;
               1: off = width - 1;
               default: off = $urandom_range(width - 1);
            endcase
            return lower + step + off;
         end
      endcase
   endfunction

   function automatic logic [tdhb_pkg::FIELD_IDX_W-1:0] pick_read_index(int unsigned n);
      if (n == 0 || $urandom_range(3) == 0)
         return $urandom_range(63);
      return $urandom_range(n - 1);
   endfunction

   task automatic add_random_requests(int n);
      int unsigned mb, zb;
      mb = bins_used(cfg_m_bins, tdhb_pkg::MAX_M_BINS);
      zb = bins_used(cfg_z_bins, tdhb_pkg::MAX_Z_BINS);
      repeat (n) begin
         if ($urandom_range(9) < 3)
            add_request(tdhb_pkg::MODE_READ, $urandom, $urandom, pick_read_index(mb),
                        pick_read_index(zb));
         else
            add_request(tdhb_pkg::MODE_ADD, pick_coord(cfg_m_lower, cfg_m_width, mb),
                        pick_coord(cfg_z_lower, cfg_z_width, zb), $urandom, $urandom);
      end
   endtask

   task automatic write_csr(logic [tdhb_pkg::CSR_INDEX_W-1:0] idx,
                            logic [tdhb_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         tdhb_pkg::CSR_M_LOWER: cfg_m_lower = data;
         tdhb_pkg::CSR_M_WIDTH: cfg_m_width = data[tdhb_pkg::WIDTH_W-1:0];
         tdhb_pkg::CSR_Z_LOWER: cfg_z_lower = data;
         tdhb_pkg::CSR_Z_WIDTH: cfg_z_width = data[tdhb_pkg::WIDTH_W-1:0];
         tdhb_pkg::CSR_M_BINS:  cfg_m_bins  = data[tdhb_pkg::BINS_W-1:0];
         tdhb_pkg::CSR_Z_BINS:  cfg_z_bins  = data[tdhb_pkg::BINS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_binning(logic [31:0] ml, logic [31:0] mw, logic [31:0] zl,
                              logic [31:0] zw, logic [31:0] mb, logic [31:0] zb);
      write_csr(tdhb_pkg::CSR_M_LOWER, ml);
      write_csr(tdhb_pkg::CSR_M_WIDTH, mw);
      write_csr(tdhb_pkg::CSR_Z_LOWER, zl);
      write_csr(tdhb_pkg::CSR_Z_WIDTH, zw);
      write_csr(tdhb_pkg::CSR_M_BINS, mb);
      write_csr(tdhb_pkg::CSR_Z_BINS, zb);
   endtask

   task automatic end_csr_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_for_idle();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_chan.valid || expected_results.size() != 0);
   endtask

   initial begin
      logic [tdhb_pkg::VALUE_W-1:0] m0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.mode = tdhb_pkg::MODE_ADD;
      req_chan.magnitude = '0;
      req_chan.redshift = '0;
      req_chan.read_m_bin = '0;
      req_chan.read_z_bin = '0;
      rsp_chan.ready = 1'b0;
      foreach (hist_counts[i])
         hist_counts[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed requests at reset binning
      m0 = tdhb_pkg::M_LOWER_RST;
      add_request(tdhb_pkg::MODE_ADD, m0, 0, 0, 0);
      add_request(tdhb_pkg::MODE_ADD, m0 + 8024, 5349, 0, 0);
      add_request(tdhb_pkg::MODE_READ, 0, 0, 0, 0);
      add_request(tdhb_pkg::MODE_ADD, m0 - 1, 0, 0, 0);
      add_request(tdhb_pkg::MODE_ADD, m0, 32'hFFFF_FFFF, 0, 0);
      add_request(tdhb_pkg::MODE_ADD, m0 + 49 * 8025, 49 * 5350, 63, 63);
      add_request(tdhb_pkg::MODE_ADD, m0 + 50 * 8025, 0, 0, 0);
      add_request(tdhb_pkg::MODE_ADD, m0, 50 * 5350, 0, 0);
      add_request(tdhb_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      add_request(tdhb_pkg::MODE_ADD, 32'h8000_0000, 32'h8000_0000, 0, 0);
      add_request(tdhb_pkg::MODE_ADD, 32'h7FFF_FFFF, 0, 0, 0);
      add_request(tdhb_pkg::MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 49, 49);
      add_request(tdhb_pkg::MODE_READ, m0, 0, 50, 0);
      add_request(tdhb_pkg::MODE_READ, 0, 0, 0, 50);
      add_request(tdhb_pkg::MODE_READ, 0, 0, 63, 63);
      add_request(tdhb_pkg::MODE_READ, 0, 0, 49, 0);
      add_request(tdhb_pkg::MODE_READ, 0, 0, 0, 0);
      add_request(tdhb_pkg::MODE_ADD, m0 + 8025, 5350, 63, 63);
      add_random_requests(200);
      wait_for_idle();

      set_binning(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 127, 64);
      end_csr_writes();
      add_random_requests(150);
      wait_for_idle();

      send_idle_pct = 63;
      recv_idle_pct = 16;
      set_binning(32'hFFFE_0000, 32'h0001_0000, 32'h0005_0000, 32'h0000_8000, 4, 3);
      end_csr_writes();
      add_random_requests(250);
      wait_for_idle();

      set_binning(0, 0, 0, 32'h100, 64, 64);
      end_csr_writes();
      add_random_requests(40);
      wait_for_idle();

      set_binning(32'h1234_5678, 1, 0, 32'h1000, 1, 0);
      write_csr(CSR_SPARE_6, $urandom);
      write_csr(CSR_SPARE_7, $urandom);
      end_csr_writes();
      add_random_requests(30);
      wait_for_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_binning(0, 1, 0, 3, 65, 64);
      end_csr_writes();
      add_random_requests(100);
      wait_for_idle();

      set_binning(tdhb_pkg::M_LOWER_RST, tdhb_pkg::M_WIDTH_RST, tdhb_pkg::Z_LOWER_RST,
                  tdhb_pkg::Z_WIDTH_RST, tdhb_pkg::M_BINS_RST, tdhb_pkg::Z_BINS_RST);
      end_csr_writes();
      add_random_requests(120);
      wait_for_idle();

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
